// ===== rtl/motion_command_queue_decoder_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MOTION_COMMAND_QUEUE_DECODER_MACROS_SVH
`define MOTION_COMMAND_QUEUE_DECODER_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define MCQD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define MCQD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/mcqd_pkg.sv =====
package mcqd_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 32;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int TEXT_W      = 64;

  // Operation codes.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Fixed command words, first character in the top byte.
  localparam logic [TEXT_W-1:0] CMD_START = 64'h5354415254303030;
  localparam logic [TEXT_W-1:0] CMD_P1L   = 64'h50314C3030303030;
  localparam logic [TEXT_W-1:0] CMD_P1R   = 64'h5031523030303030;
  localparam logic [TEXT_W-1:0] CMD_P2L   = 64'h50324C3030303030;
  localparam logic [TEXT_W-1:0] CMD_P2R   = 64'h5032523030303030;
  localparam logic [TEXT_W-1:0] CMD_END0  = 64'h454E443030303030;
  localparam logic [TEXT_W-1:0] CMD_END1  = 64'h454E443030303031;

  // Characters that steer the decode.
  localparam logic [7:0] CHR_F    = 8'h46;
  localparam logic [7:0] CHR_B    = 8'h42;
  localparam logic [7:0] CHR_S    = 8'h53;
  localparam logic [7:0] CHR_A    = 8'h41;
  localparam logic [7:0] CHR_Q    = 8'h51;
  localparam logic [7:0] CHR_W    = 8'h57;
  localparam logic [7:0] CHR_E    = 8'h45;
  localparam logic [7:0] CHR_R    = 8'h52;
  localparam logic [7:0] CHR_T    = 8'h54;
  localparam logic [7:0] CHR_D    = 8'h44;
  localparam logic [7:0] CHR_ZERO = 8'd48;

  typedef struct packed {
    logic              operation;
    logic [TEXT_W-1:0] command_text;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        stop_reply;
    logic        drive_forward;
    logic [7:0]  movement_code;
    logic [31:0] move_amount;
    logic [15:0] ends_seen;
    logic        waiting_flag;
    logic        queue_idle;
    logic [5:0]  entries_held;
  } out_t;

  // Motion state that persists between words.
  typedef struct packed {
    logic        forward;
    logic [7:0]  movement;
    logic [31:0] amount;
    logic [15:0] ends;
    logic        waiting;
  } held_t;

  // What decoding one dequeued word yields.
  typedef struct packed {
    logic  accepted;
    logic  stop;
    held_t held;
  } dec_res_t;

endpackage

// ===== rtl/mcqd_ram.sv =====
module mcqd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  logic [WIDTH-1:0]               wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic [WIDTH-1:0]               rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mcqd_decode.sv =====
module mcqd_decode (
  input  logic [mcqd_pkg::TEXT_W-1:0] text,
  input  mcqd_pkg::held_t             held,
  output mcqd_pkg::dec_res_t          res
);

  import mcqd_pkg::*;

  // Place weights of a six-digit magnitude, most significant first.
  localparam logic [31:0] WEIGHT [6] = '{32'd100000, 32'd10000, 32'd1000,
                                         32'd100, 32'd10, 32'd1};

  logic [7:0]  first_chr;
  logic [7:0]  second_chr;
  logic [31:0] term [6];
  logic [31:0] amount6;
  logic [31:0] amount2;

  assign first_chr  = text[63:56];
  assign second_chr = text[55:48];

  // Each character counts as its code minus the code of zero, all modulo 2^32.
  always_comb begin
    amount6 = '0;
    for (int i = 0; i < 6; i++) begin
      term[i] = (32'(text[47-8*i -: 8]) - 32'(CHR_ZERO)) * WEIGHT[i];
      amount6 = amount6 + term[i];
    end
  end

  assign amount2 = ((32'(text[15:8]) - 32'(CHR_ZERO)) * 32'd10)
                 + (32'(text[7:0]) - 32'(CHR_ZERO));

  always_comb begin
    res          = '0;
    res.held     = held;
    if (text == CMD_START) begin
      res.held.movement = CHR_Q;
      res.accepted      = 1'b1;
    end else if (text == CMD_P1L) begin
      res.held.movement = CHR_W;
      res.accepted      = 1'b1;
    end else if (text == CMD_P1R) begin
      res.held.movement = CHR_E;
      res.accepted      = 1'b1;
    end else if (text == CMD_P2L) begin
      res.held.movement = CHR_R;
      res.accepted      = 1'b1;
    end else if (text == CMD_P2R) begin
      res.held.movement = CHR_T;
      res.accepted      = 1'b1;
    end else if (text == CMD_END0) begin
      res.held.ends    = held.ends + 16'd1;
      res.held.waiting = 1'b1;
      res.stop         = 1'b1;
    end else if (text == CMD_END1) begin
      res.held.waiting = 1'b1;
    end else if (first_chr == CHR_F || first_chr == CHR_B) begin
      res.held.forward  = (first_chr == CHR_F);
      res.held.movement = second_chr;
      res.held.amount   = (second_chr != CHR_A) ? amount6 : 32'd0;
      res.accepted      = 1'b1;
    end else if (first_chr == CHR_S) begin
      res.held.forward  = 1'b1;
      res.held.movement = CHR_D;
      res.held.amount   = amount2;
      res.accepted      = 1'b1;
    end
  end

endmodule

// ===== rtl/motion_command_queue_decoder.sv =====
// Channel | Ports                           | Role
// in      | in_valid, in_ready, in_data     | command word in: enqueue or dequeue request
// out     | out_valid, out_ready, out_data  | one status word per command word
//
// A word accepted at the input is held in stage one while its store read is registered;
// its result word is then registered in the result register, where it can be taken. One
// word per cycle can be sustained when the result side keeps out_ready high.
// The latency is set by the registered read port of the command store.
// rst_n is synchronous and clears the queue pointers, the fill level and the held motion
// state, and sets the waiting flag; store contents are not cleared.
// A stall on the result side holds the result word and then the stage behind it, after
// which in_ready drops until the result word is taken.
module motion_command_queue_decoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mcqd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mcqd_pkg::out_t out_data
);

  import mcqd_pkg::*;

  // Stage one registers: what the queue bookkeeping decided when the word came in.
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_op_r;
  logic              s1_hit_r;
  logic              s1_end_r;
  logic [FILL_W-1:0] s1_fill_r;

  // Queue bookkeeping.
  logic [ADDR_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [ADDR_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // Persistent motion state and the result register.
  held_t held_r, held_nxt;
  logic  out_valid_r, out_valid_nxt;
  out_t  out_data_r, out_data_nxt;

  logic              in_fire;
  logic              s2_adv;
  logic              is_enq;
  logic              hit;
  logic              ram_wr;
  logic              ram_rd;
  logic [TEXT_W-1:0] ram_rdata;
  dec_res_t          dec;
  logic              accepted;
  logic              stop;

  // The result register frees when it is empty or being taken; stage one moves into it
  // whenever it frees, so stage one only blocks the input while the result side stalls.
  assign s2_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_adv;
  assign in_fire  = in_valid && in_ready;

  assign is_enq = (in_data.operation == OP_ENQUEUE);
  assign hit    = is_enq ? (fill_r != FILL_W'(QUEUE_DEPTH)) : (fill_r != '0);
  assign ram_wr = in_fire && is_enq && hit;
  assign ram_rd = in_fire && !is_enq && hit;

  // A dequeue can only reach an entry written by an earlier enqueue, whose write has
  // already landed by the time the read is clocked.
  mcqd_ram #(
    .WIDTH (TEXT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (wr_slot_r),
    .wr_data (in_data.command_text),
    .rd_en   (ram_rd),
    .rd_addr (rd_slot_r),
    .rd_data (ram_rdata)
  );

  always_comb begin
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    fill_nxt    = fill_r;
    if (ram_wr) begin
      wr_slot_nxt = (wr_slot_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_slot_r + 1'b1;
      fill_nxt    = fill_r + 1'b1;
    end
    if (ram_rd) begin
      rd_slot_nxt = (rd_slot_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_slot_r + 1'b1;
      fill_nxt    = fill_r - 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wr_slot_r  <= '0;
      rd_slot_r  <= '0;
      fill_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      wr_slot_r  <= wr_slot_nxt;
      rd_slot_r  <= rd_slot_nxt;
      fill_r     <= fill_nxt;
    end
  end

  // Stage one payload. The END check on an enqueue is done here so that the text
  // itself need not be carried forward.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_data.operation;
      s1_hit_r  <= hit;
      s1_end_r  <= (in_data.command_text == CMD_END0) ||
                   (in_data.command_text == CMD_END1);
      s1_fill_r <= fill_nxt;
    end
  end

  // Stage two: decode the word read from the store against the held motion state.
  mcqd_decode u_decode (
    .text (ram_rdata),
    .held (held_r),
    .res  (dec)
  );

  always_comb begin
    held_nxt = held_r;
    accepted = 1'b0;
    stop     = 1'b0;
    if (s1_op_r == OP_ENQUEUE) begin
      accepted = s1_hit_r;
      if (s1_hit_r && s1_end_r) begin
        held_nxt.waiting = 1'b0;
      end
    end else if (s1_hit_r) begin
      held_nxt = dec.held;
      accepted = dec.accepted;
      stop     = dec.stop;
    end
  end

  always_comb begin
    out_data_nxt               = out_data_r;
    out_data_nxt.accepted      = accepted;
    out_data_nxt.stop_reply    = stop;
    out_data_nxt.drive_forward = held_nxt.forward;
    out_data_nxt.movement_code = held_nxt.movement;
    out_data_nxt.move_amount   = held_nxt.amount;
    out_data_nxt.ends_seen     = held_nxt.ends;
    out_data_nxt.waiting_flag  = held_nxt.waiting;
    out_data_nxt.queue_idle    = (s1_fill_r == '0) || held_nxt.waiting;
    out_data_nxt.entries_held  = 6'(s1_fill_r);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_r      <= '{forward: 1'b0, movement: 8'd0, amount: 32'd0,
                       ends: 16'd0, waiting: 1'b1};
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_valid_r && s2_adv) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/mcqd_checker.sv =====
`include "motion_command_queue_decoder_macros.svh"

module mcqd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input mcqd_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input mcqd_pkg::out_t out_data
);

  import mcqd_pkg::*;

  `MCQD_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "out_valid after reset")

  `MCQD_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data), "input word changed while waiting")

  `MCQD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")

  `MCQD_ASSERT(a_stop_reply, out_valid && out_data.stop_reply |-> !out_data.accepted && out_data.waiting_flag && out_data.queue_idle, "stop reply without waiting")

  `MCQD_ASSERT(a_idle_flag, out_valid |-> out_data.queue_idle == ((out_data.entries_held == 6'd0) || out_data.waiting_flag), "queue_idle inconsistent")

endmodule

bind motion_command_queue_decoder mcqd_checker u_mcqd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
